FILE: rtl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg: shared types and constants of the LZW (.Z) body decoder
// Widths, special codes, register indexes, result codes and the
// control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int MAX_BITS    = 16;
  localparam int TABLE_DEPTH = 1 << MAX_BITS;
  localparam int CODE_W      = MAX_BITS;
  localparam int CNT_W       = MAX_BITS + 1;
  localparam int WID_W       = 5;
  localparam int BUF_W       = 24;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CNT_W-1:0]  CLEAR_CODE   = CNT_W'(256);
  localparam logic [CNT_W-1:0]  FIRST_FREE_B = CNT_W'(257);
  localparam logic [CNT_W-1:0]  FIRST_FREE_N = CNT_W'(256);
  localparam logic [WID_W-1:0]  FIRST_WIDTH  = WID_W'(9);
  localparam logic [WID_W-1:0]  LIMIT_HIGH   = WID_W'(MAX_BITS);
  localparam logic [WID_W-1:0]  RESET_MAXBIT = WID_W'(16);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CODE_BITS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MODE    = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_INVALID = 2'd2,
    ST_FAILED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_CHECK,
    S_WALK,
    S_FETCH,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_POP_DONE,
    OP_CHECK,
    OP_WALK,
    OP_FETCH,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic go_pop;
    logic go_check;
    logic check_walk;
    logic walk_more;
    logic res_busy;
  } sts_t;

endpackage

FILE: rtl/lzwd_ram.sv
// ----------------------------------------------------------------------------
// lzwd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lzwd_ctrl.sv
// ----------------------------------------------------------------------------
// lzwd_ctrl: sequencer of the decoder
// Steps each item through a pop, or a code check, chain walk and table update.
// ----------------------------------------------------------------------------
module lzwd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              cfg_valid,
  input  lzwd_pkg::sts_t    sts,
  output lzwd_pkg::cmd_t    cmd,
  output lzwd_pkg::state_t state,
  output logic              in_stall,
  output logic              cfg_ready
);

  lzwd_pkg::state_t state_next;
  logic             accept;

  assign cfg_ready = (state == lzwd_pkg::S_IDLE);
  // config takes the idle cycle ahead of an input beat
  assign in_stall  = (state != lzwd_pkg::S_IDLE) || sts.res_busy || cfg_valid;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzwd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = lzwd_pkg::OP_NONE;
    case (state)
      lzwd_pkg::S_IDLE: begin
        if (accept) begin
          cmd.op = lzwd_pkg::OP_ACCEPT;
          if (sts.go_pop) begin
            state_next = lzwd_pkg::S_POP;
          end else if (sts.go_check) begin
            state_next = lzwd_pkg::S_CHECK;
          end
        end
      end
      lzwd_pkg::S_POP: begin
        cmd.op     = lzwd_pkg::OP_POP_DONE;
        state_next = lzwd_pkg::S_IDLE;
      end
      lzwd_pkg::S_CHECK: begin
        cmd.op     = lzwd_pkg::OP_CHECK;
        state_next = sts.check_walk ? lzwd_pkg::S_WALK : lzwd_pkg::S_IDLE;
      end
      lzwd_pkg::S_WALK: begin
        cmd.op     = lzwd_pkg::OP_WALK;
        state_next = sts.walk_more ? lzwd_pkg::S_FETCH : lzwd_pkg::S_FINISH;
      end
      lzwd_pkg::S_FETCH: begin
        cmd.op     = lzwd_pkg::OP_FETCH;
        state_next = lzwd_pkg::S_WALK;
      end
      lzwd_pkg::S_FINISH: begin
        cmd.op     = lzwd_pkg::OP_FINISH;
        state_next = lzwd_pkg::S_IDLE;
      end
      default: begin
        state_next = lzwd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/lzwd_dp.sv
// ----------------------------------------------------------------------------
// lzwd_dp: datapath of the decoder
// Bit packer, dictionary and output stack memories, stream state and the
// result register.
// ----------------------------------------------------------------------------
module lzwd_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  lzwd_pkg::cmd_t                     cmd,
  output lzwd_pkg::sts_t                     sts,
  input  logic                               kind,
  input  logic [7:0]                         in_byte,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [lzwd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lzwd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [7:0]                         out_byte,
  output logic                               out_valid,
  output logic                               string_end,
  output logic [1:0]                         status
);

  localparam int CW = lzwd_pkg::CODE_W;
  localparam int NW = lzwd_pkg::CNT_W;
  localparam int WW = lzwd_pkg::WID_W;
  localparam int BW = lzwd_pkg::BUF_W;

  // stream state
  logic [WW-1:0] max_bits, max_bits_next;
  logic          blk, blk_next;
  logic [NW-1:0] cnt, cnt_next;
  logic [NW-1:0] nfc, nfc_next;
  logic [WW-1:0] cw, cw_next;
  logic [CW-1:0] pcode, pcode_next;
  logic          pv, pv_next;
  logic [7:0]    pfb, pfb_next;
  logic [BW-1:0] buff, buff_next;
  logic [WW-1:0] bc, bc_next;
  logic [WW-1:0] gbc, gbc_next;
  logic [WW-1:0] skip, skip_next;
  logic          err, err_next;
  logic [CW-1:0] code, code_next;
  logic [CW-1:0] c, c_next;
  logic [7:0]    fb, fb_next;

  // result register
  logic          res_valid_next;
  logic [7:0]    out_byte_next;
  logic          out_valid_next, string_end_next;
  logic [1:0]    status_next;

  // memory ports
  logic          stk_we, tbl_we;
  logic [CW-1:0] stk_waddr, stk_raddr;
  logic [7:0]    stk_wdata, stk_rdata;
  logic [CW-1:0] pre_rdata;
  logic [7:0]    suf_rdata;

  // derived values
  logic [NW-1:0] first;
  logic [WW-1:0] lim;
  logic [NW-1:0] lim_pow, cw_pow;
  logic [BW-1:0] buf_or, buf_sh, mask;
  logic [WW-1:0] bc8, gbc_inc;
  logic          got;
  logic [CW-1:0] code_new;
  logic          is_clear, invalid, kwk;
  logic [NW-1:0] nfc_add;
  logic          add;
  logic          chg;
  logic [WW-1:0] chg_w;
  logic          push;
  logic [7:0]    push_byte;
  logic          restart;
  logic          new_blk;

  lzwd_ram #(.WIDTH(8), .DEPTH(lzwd_pkg::TABLE_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  lzwd_ram #(.WIDTH(CW), .DEPTH(lzwd_pkg::TABLE_DEPTH)) u_prefix (
    .clk(clk), .we(tbl_we), .waddr(nfc[CW-1:0]), .wdata(pcode),
    .raddr(c), .rdata(pre_rdata)
  );

  lzwd_ram #(.WIDTH(8), .DEPTH(lzwd_pkg::TABLE_DEPTH)) u_suffix (
    .clk(clk), .we(tbl_we), .waddr(nfc[CW-1:0]), .wdata(fb),
    .raddr(c), .rdata(suf_rdata)
  );

  assign first = blk ? lzwd_pkg::FIRST_FREE_B : lzwd_pkg::FIRST_FREE_N;
  assign lim   = (max_bits < lzwd_pkg::FIRST_WIDTH) ? lzwd_pkg::FIRST_WIDTH :
                 (max_bits > lzwd_pkg::LIMIT_HIGH) ? lzwd_pkg::LIMIT_HIGH : max_bits;
  assign lim_pow = NW'(1) << lim;
  assign cw_pow  = NW'(1) << cw;

  assign buf_or   = buff | (BW'(in_byte) << bc);
  assign bc8      = bc + WW'(8);
  assign gbc_inc  = gbc + WW'(1);
  assign got      = (bc8 >= cw);
  assign mask     = (BW'(1) << cw) - BW'(1);
  assign code_new = buf_or[CW-1:0] & mask[CW-1:0];
  assign buf_sh   = buf_or >> cw;

  assign is_clear = blk && ({1'b0, code} == lzwd_pkg::CLEAR_CODE);
  assign kwk      = ({1'b0, code} == nfc);
  assign invalid  = ({1'b0, code} > nfc) || (kwk && !pv);
  assign add      = pv && (nfc < lim_pow);
  assign nfc_add  = add ? nfc + NW'(1) : nfc;

  assign stk_raddr = CW'(cnt - NW'(1));
  assign stk_we    = push && !cnt[NW-1];
  assign stk_waddr = cnt[CW-1:0];
  assign stk_wdata = push_byte;
  assign tbl_we    = (cmd.op == lzwd_pkg::OP_FINISH) && add;

  assign restart = cfg_valid && cfg_ready &&
                   ((cfg_index == lzwd_pkg::CFG_MAX_CODE_BITS) ||
                    (cfg_index == lzwd_pkg::CFG_BLOCK_MODE));
  assign new_blk = (cfg_index == lzwd_pkg::CFG_BLOCK_MODE) ? cfg_data[0] : blk;

  assign sts.go_pop     = kind && (cnt != '0);
  assign sts.go_check   = !kind && !err && (cnt == '0) && (skip == '0) && got;
  assign sts.check_walk = !is_clear && !invalid;
  assign sts.walk_more  = ({1'b0, c} >= first) && !cnt[NW-1];
  assign sts.res_busy   = res_valid && res_stall;

  always_comb begin
    max_bits_next = max_bits;
    blk_next      = blk;
    cnt_next      = cnt;
    nfc_next      = nfc;
    cw_next       = cw;
    pcode_next    = pcode;
    pv_next       = pv;
    pfb_next      = pfb;
    buff_next     = buff;
    bc_next       = bc;
    gbc_next      = gbc;
    skip_next     = skip;
    err_next      = err;
    code_next     = code;
    c_next        = c;
    fb_next       = fb;
    res_valid_next  = res_valid && res_stall;
    out_byte_next   = out_byte;
    out_valid_next  = out_valid;
    string_end_next = string_end;
    status_next     = status;
    chg       = 1'b0;
    chg_w     = cw;
    push      = 1'b0;
    push_byte = 8'd0;

    case (cmd.op)
      lzwd_pkg::OP_ACCEPT: begin
        if (kind) begin
          if (cnt != '0) begin
            cnt_next = cnt - NW'(1);
          end else begin
            res_valid_next  = 1'b1;
            out_byte_next   = 8'd0;
            out_valid_next  = 1'b0;
            string_end_next = 1'b0;
            status_next     = err ? lzwd_pkg::ST_FAILED : lzwd_pkg::ST_OK;
          end
        end else begin
          res_valid_next  = 1'b1;
          out_byte_next   = 8'd0;
          out_valid_next  = 1'b0;
          string_end_next = 1'b0;
          status_next     = lzwd_pkg::ST_OK;
          if (err) begin
            status_next = lzwd_pkg::ST_FAILED;
          end else if (cnt != '0) begin
            status_next = lzwd_pkg::ST_REFUSED;
          end else if (skip != '0) begin
            skip_next = skip - WW'(1);
          end else begin
            buff_next = got ? buf_sh : buf_or;
            bc_next   = got ? bc8 - cw : bc8;
            gbc_next  = (gbc_inc >= cw) ? '0 : gbc_inc;
            code_next = code_new;
            // a whole code goes on to the check step
            res_valid_next = !got;
          end
        end
      end
      lzwd_pkg::OP_POP_DONE: begin
        res_valid_next  = 1'b1;
        out_byte_next   = stk_rdata;
        out_valid_next  = 1'b1;
        string_end_next = (cnt == '0);
        status_next     = lzwd_pkg::ST_OK;
      end
      lzwd_pkg::OP_CHECK: begin
        if (is_clear) begin
          chg      = 1'b1;
          chg_w    = lzwd_pkg::FIRST_WIDTH;
          nfc_next = first;
          pv_next  = 1'b0;
        end else if (invalid) begin
          err_next = 1'b1;
        end else begin
          cnt_next = kwk ? NW'(1) : '0;
          c_next   = kwk ? pcode : code;
        end
        if (is_clear || invalid) begin
          res_valid_next  = 1'b1;
          out_byte_next   = 8'd0;
          out_valid_next  = 1'b0;
          string_end_next = 1'b0;
          status_next     = invalid && !is_clear ? lzwd_pkg::ST_INVALID : lzwd_pkg::ST_OK;
        end
      end
      lzwd_pkg::OP_WALK: begin
        if (!sts.walk_more) begin
          fb_next   = c[7:0];
          push      = 1'b1;
          push_byte = c[7:0];
        end
      end
      lzwd_pkg::OP_FETCH: begin
        push      = 1'b1;
        push_byte = suf_rdata;
        c_next    = pre_rdata;
      end
      lzwd_pkg::OP_FINISH: begin
        nfc_next   = nfc_add;
        pcode_next = code;
        pv_next    = 1'b1;
        pfb_next   = fb;
        if ((nfc_add >= cw_pow) && (cw < lim)) begin
          chg   = 1'b1;
          chg_w = cw + WW'(1);
        end
        res_valid_next  = 1'b1;
        out_byte_next   = 8'd0;
        out_valid_next  = 1'b0;
        string_end_next = 1'b0;
        status_next     = lzwd_pkg::ST_OK;
      end
      default: begin
      end
    endcase

    // the KwKwK byte lands at the bottom of the stack
    if ((cmd.op == lzwd_pkg::OP_CHECK) && !is_clear && !invalid && kwk) begin
      push      = 1'b1;
      push_byte = pfb;
    end
    if (cmd.op == lzwd_pkg::OP_CHECK) begin
      if (stk_we) begin
        cnt_next = NW'(1);
      end
    end else if (stk_we) begin
      cnt_next = cnt + NW'(1);
    end

    // width change: drop the rest of the current code group
    if (chg) begin
      skip_next = (gbc != '0) ? cw - gbc : '0;
      gbc_next  = '0;
      buff_next = '0;
      bc_next   = '0;
      cw_next   = chg_w;
    end

    if (restart) begin
      if (cfg_index == lzwd_pkg::CFG_MAX_CODE_BITS) begin
        max_bits_next = cfg_data[WW-1:0];
      end else begin
        blk_next = cfg_data[0];
      end
      cnt_next  = '0;
      nfc_next  = new_blk ? lzwd_pkg::FIRST_FREE_B : lzwd_pkg::FIRST_FREE_N;
      cw_next   = lzwd_pkg::FIRST_WIDTH;
      pcode_next = '0;
      pv_next   = 1'b0;
      pfb_next  = 8'd0;
      buff_next = '0;
      bc_next   = '0;
      gbc_next  = '0;
      skip_next = '0;
      err_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bits  <= lzwd_pkg::RESET_MAXBIT;
      blk       <= 1'b1;
      cnt       <= '0;
      nfc       <= lzwd_pkg::FIRST_FREE_B;
      cw        <= lzwd_pkg::FIRST_WIDTH;
      pcode     <= '0;
      pv        <= 1'b0;
      pfb       <= 8'd0;
      buff      <= '0;
      bc        <= '0;
      gbc       <= '0;
      skip      <= '0;
      err       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      max_bits  <= max_bits_next;
      blk       <= blk_next;
      cnt       <= cnt_next;
      nfc       <= nfc_next;
      cw        <= cw_next;
      pcode     <= pcode_next;
      pv        <= pv_next;
      pfb       <= pfb_next;
      buff      <= buff_next;
      bc        <= bc_next;
      gbc       <= gbc_next;
      skip      <= skip_next;
      err       <= err_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    code       <= code_next;
    c          <= c_next;
    fb         <= fb_next;
    out_byte   <= out_byte_next;
    out_valid  <= out_valid_next;
    string_end <= string_end_next;
    status     <= status_next;
  end

endmodule

FILE: rtl/lzw_compress_decoder.sv
// ----------------------------------------------------------------------------
// lzw_compress_decoder: Unix compress (.Z) LZW body decoder, 9 to 16 bit codes
// Controller and datapath around a 64K-entry dictionary and output stack.
// ----------------------------------------------------------------------------
// Feed the compressed bytes that follow the three-byte .Z header (kind 0) and
// pop decoded bytes (kind 1); every input beat yields exactly one result beat.
// Software parses the header and writes max_code_bits (index 0) and
// block_mode (index 1); either write restarts the stream. A feed that leaves
// no whole code, is dropped as group padding, is refused or meets a latched
// error finishes at acceptance in the idle state, as does a pop of an empty
// stack; a pop of a pending byte goes on to the pop state for the stack read.
// A feed that completes a code goes on to the check state, where a clear or
// an invalid code ends; any other code alternates the walk and fetch states,
// which read the prefix and suffix memories once per link (a KwKwK code needs
// no table read for its repeated first byte). A result held by res_stall
// holds off the next input beat. Feeds are refused (status 1) while decoded
// bytes remain on the stack, so drain with pops after each code.
// An invalid code latches status 2, then every beat reports 3 until a write
// of index 0 or 1, or reset. Dictionary memories need no clearing.
module lzw_compress_decoder (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic [7:0]                         in_byte,
  // result channel
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [7:0]                         out_byte,
  output logic                               out_valid,
  output logic                               string_end,
  output logic [1:0]                         status,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lzwd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lzwd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  lzwd_pkg::cmd_t   cmd;
  lzwd_pkg::sts_t   sts;
  lzwd_pkg::state_t state;

  // sequencer: one item in flight, handshakes on the idle state
  lzwd_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .cfg_valid(cfg_valid),
    .sts(sts), .cmd(cmd), .state(state),
    .in_stall(in_stall), .cfg_ready(cfg_ready)
  );

  // bit packer, dictionary, stack and result register
  lzwd_dp u_dp (
    .clk(clk), .rst(rst),
    .cmd(cmd), .sts(sts),
    .kind(kind), .in_byte(in_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .res_valid(res_valid), .res_stall(res_stall),
    .out_byte(out_byte), .out_valid(out_valid),
    .string_end(string_end), .status(status)
  );

  // hold off input while an item is being worked on
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != lzwd_pkg::S_IDLE) |-> in_stall)
    else $error("input taken while an item is in progress");

  // a string end only ever marks a popped byte
  a_end_popped: assert property (@(posedge clk) disable iff (rst)
    (res_valid && string_end) |-> (out_valid && (status == lzwd_pkg::ST_OK)))
    else $error("string end without a popped byte");

  // a pop always delivers its result the cycle after the stack read
  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    (state == lzwd_pkg::S_POP) |=> (res_valid && out_valid))
    else $error("pop did not deliver a byte");

endmodule

FILE: sim/tb_lzw_compress_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lzw_compress_decoder: self-checking bench for the .Z LZW body decoder
// Encodes random byte strings as compress(1) streams, feeds them with pops in
// between, and checks every result beat against a built-in decoder model.
// ----------------------------------------------------------------------------
module tb_lzw_compress_decoder;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } beat_in_t;

  typedef struct packed {
    logic [7:0] obyte;
    logic       ovalid;
    logic       send;
    logic [1:0] stat;
  } beat_out_t;

  localparam logic KIND_FEED = 1'b0;
  localparam logic KIND_POP  = 1'b1;
  localparam int   LIMIT_CYCLES = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, kind = 1'b0;
  logic [7:0] in_byte = '0;
  logic in_stall, res_valid, res_stall = 1'b0;
  logic [7:0] out_byte;
  logic out_valid, string_end;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lzwd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lzwd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  lzw_compress_decoder dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- decoder model: its own copy of the dictionary and stream state ----
  logic [15:0] dict_prefix [lzwd_pkg::TABLE_DEPTH];
  logic [7:0]  dict_suffix [lzwd_pkg::TABLE_DEPTH];
  logic [7:0]  pend_stack  [lzwd_pkg::TABLE_DEPTH];
  int unsigned pend_cnt, free_code, cur_width, prev_code, prev_first;
  bit          prev_ok, failed;
  int unsigned bitbuf, bitcnt, grp_cnt, pad_left;
  int unsigned m_maxbits = 16;
  bit          m_block = 1'b1;

  function automatic int unsigned width_cap();
    if (m_maxbits < 9) return 9;
    if (m_maxbits > lzwd_pkg::MAX_BITS) return lzwd_pkg::MAX_BITS;
    return m_maxbits;
  endfunction

  function automatic int unsigned base_code();
    return m_block ? 257 : 256;
  endfunction

  function automatic void stream_restart();
    pend_cnt = 0; free_code = base_code(); cur_width = 9;
    prev_code = 0; prev_ok = 0; prev_first = 0;
    bitbuf = 0; bitcnt = 0; grp_cnt = 0; pad_left = 0; failed = 0;
  endfunction

  // Skip what is left of the current code group, then widen.
  function automatic void widen(int unsigned w);
    pad_left = grp_cnt ? cur_width - grp_cnt : 0;
    grp_cnt = 0; bitbuf = 0; bitcnt = 0; cur_width = w;
  endfunction

  function automatic void stack_push(int unsigned b);
    if (pend_cnt < lzwd_pkg::TABLE_DEPTH) begin
      pend_stack[pend_cnt] = b[7:0];
      pend_cnt++;
    end
  endfunction

  function automatic logic [1:0] expand_code(int unsigned code);
    int unsigned c, fb;
    c = code;
    if (m_block && code == 256) begin
      widen(9); free_code = base_code(); prev_ok = 0;
      return lzwd_pkg::ST_OK;
    end
    if (code > free_code || (code == free_code && !prev_ok)) begin
      failed = 1;
      return lzwd_pkg::ST_INVALID;
    end
    pend_cnt = 0;
    if (code == free_code) begin
      stack_push(prev_first);
      c = prev_code;
    end
    while (c >= base_code() && pend_cnt < lzwd_pkg::TABLE_DEPTH) begin
      stack_push(dict_suffix[c[15:0]]);
      c = dict_prefix[c[15:0]];
    end
    fb = c & 8'hff;
    stack_push(fb);
    if (prev_ok && free_code < (1 << width_cap())) begin
      dict_prefix[free_code[15:0]] = prev_code[15:0];
      dict_suffix[free_code[15:0]] = fb[7:0];
      free_code++;
    end
    prev_code = code & 16'hffff; prev_ok = 1; prev_first = fb;
    if (free_code >= (1 << cur_width) && cur_width < width_cap()) widen(cur_width + 1);
    return lzwd_pkg::ST_OK;
  endfunction

  function automatic beat_out_t decode_beat(beat_in_t b);
    beat_out_t r;
    int unsigned code;
    r = '0;
    if (b.kind == KIND_POP) begin
      if (pend_cnt > 0) begin
        pend_cnt--;
        r.obyte = pend_stack[pend_cnt]; r.ovalid = 1; r.send = (pend_cnt == 0);
      end else if (failed) r.stat = lzwd_pkg::ST_FAILED;
    end else if (failed) r.stat = lzwd_pkg::ST_FAILED;
    else if (pend_cnt > 0) r.stat = lzwd_pkg::ST_REFUSED;
    else if (pad_left > 0) pad_left--;
    else begin
      bitbuf |= b.data << bitcnt;
      bitcnt += 8;
      grp_cnt++;
      if (grp_cnt >= cur_width) grp_cnt = 0;
      if (bitcnt >= cur_width) begin
        code = bitbuf & ((1 << cur_width) - 1);
        bitbuf >>= cur_width;
        bitcnt -= cur_width;
        r.stat = expand_code(code);
      end
      bitbuf &= 24'hffffff;
    end
    return r;
  endfunction

  // ---- stimulus and expectations ----
  beat_in_t  pending_beats[$];
  beat_out_t expected_beats[$];
  int unsigned mismatches = 0, cycle_count = 0;
  int unsigned send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_req = 1'b0, hold_off = 1'b0;
  int unsigned hold_left = 0;

  // Append one beat to the tail of the pending queue.
  function automatic void queue_beat(logic k, logic [7:0] d);
    beat_in_t b;
    b = {k, d};
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // Accepted beats are predicted in acceptance order.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_beats.insert(expected_beats.size(), decode_beat({kind, in_byte}));
    end
  end

  // Driver: a valid stays up until taken; only the idle decision varies.
  always @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (!(in_valid && in_stall)) begin
      if (in_valid && !in_stall) void'(pending_beats.pop_front());
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        kind     <= pending_beats[0].kind;
        in_byte  <= pending_beats[0].data;
      end else in_valid <= 1'b0;
    end
  end

  // Long receiver hold-off, counted here once requested.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_off  <= 1'b1;
      hold_left <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) hold_off <= 1'b0;
    end
  end

  always @(posedge clk) begin
    res_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    beat_out_t got, want;
    if (!rst && res_valid && !res_stall) begin
      got = {out_byte, out_valid, string_end, status};
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: byte %h/%h valid %b/%b end %b/%b status %0d/%0d",
                     want.obyte, got.obyte, want.ovalid, got.ovalid,
                     want.send, got.send, want.stat, got.stat);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_lzw_compress_decoder: done, errors");
      $finish;
    end
  end

  // ---- encoder side: build a well-formed stream for the current setting ----
  byte unsigned enc_bytes[$];
  int unsigned  enc_acc, enc_bits, enc_grp, enc_w, enc_free;

  function automatic void emit_byte(byte unsigned b);
    enc_bytes.insert(enc_bytes.size(), b);
  endfunction

  task automatic put_code(int unsigned code);
    enc_acc |= code << enc_bits;
    enc_bits += enc_w;
    enc_grp++;
    while (enc_bits >= 8) begin
      emit_byte(enc_acc[7:0]);
      enc_acc >>= 8; enc_bits -= 8;
    end
  endtask

  // Flush the group to a whole number of codes, as compress(1) pads it.
  task automatic pad_group();
    if (enc_bits > 0) begin
      emit_byte(enc_acc[7:0]);
      enc_acc = 0; enc_bits = 0;
    end
    // bytes of the group written so far = ceil(grp*w/8); pad to w bytes
    if (enc_grp % 8 != 0) begin
      int unsigned used;
      used = ((enc_grp % 8) * enc_w + 7) / 8;
      repeat (enc_w - used) emit_byte(8'($urandom_range(255)));
    end
    enc_grp = 0;
  endtask

  // Encode codes with a simple dictionary walk over random data.
  task automatic build_stream(int unsigned n_codes, int unsigned alpha);
    int unsigned dict[int unsigned];
    int unsigned w_code, k, key, cap, base;
    bit have;
    cap = width_cap(); base = base_code();
    enc_bytes.delete(); enc_acc = 0; enc_bits = 0; enc_grp = 0;
    enc_w = 9; enc_free = base; have = 0; w_code = 0;
    while (n_codes > 0) begin
      k = $urandom_range(alpha);
      if (!have) begin w_code = k; have = 1; continue; end
      key = (w_code << 8) | k;
      if (dict.exists(key)) begin w_code = dict[key]; continue; end
      put_code(w_code); n_codes--;
      if (enc_free < (1 << cap)) begin
        dict[key] = enc_free; enc_free++;
        // decoder adds its entry one code late, so widen when it will
        if (enc_free > (1 << enc_w) && enc_w < cap) begin
          pad_group(); enc_w++;
        end
      end
      w_code = k;
      if (m_block && n_codes > 2 && $urandom_range(40) == 0) begin
        put_code(w_code); put_code(256); pad_group();
        enc_w = 9; enc_free = base; dict.delete(); have = 0; n_codes -= 2;
      end
    end
    if (have) put_code(w_code);
    if (enc_bits > 0) emit_byte(enc_acc[7:0]);
  endtask

  // Queue each feed with up to three pops; extra pops hit the empty stack.
  task automatic queue_stream();
    foreach (enc_bytes[i]) begin
      queue_beat(KIND_FEED, enc_bytes[i]);
      repeat ($urandom_range(0, 3) == 0 ? 0 : 1 + $urandom_range(2))
        queue_beat(KIND_POP, 8'($urandom_range(255)));
    end
    repeat (6) queue_beat(KIND_POP, 8'h00);
  endtask

  task automatic drain_all();
    while (pending_beats.size() != 0 || expected_beats.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [lzwd_pkg::CFG_IDX_W-1:0] idx,
                           logic [lzwd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == lzwd_pkg::CFG_MAX_CODE_BITS) begin
      m_maxbits = val[4:0]; stream_restart();
    end else if (idx == lzwd_pkg::CFG_BLOCK_MODE) begin
      m_block = val[0]; stream_restart();
    end
  endtask

  initial begin
    stream_restart();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every field extreme, empty pops, invalid code, latched failure.
    queue_beat(KIND_POP, 8'hff);
    queue_beat(KIND_FEED, 8'h41);
    queue_beat(KIND_FEED, 8'h00);
    queue_beat(KIND_FEED, 8'h00);
    queue_beat(KIND_POP, 8'h00);
    queue_beat(KIND_POP, 8'h00);
    queue_beat(KIND_FEED, 8'hff);
    queue_beat(KIND_FEED, 8'hff);
    queue_beat(KIND_FEED, 8'h00);
    queue_beat(KIND_POP, 8'h00);
    drain_all();
    // KwKwK: 'a' then code 257 in block mode; an index past the registers too
    write_reg(8'd2, 8'hff);
    write_reg(lzwd_pkg::CFG_BLOCK_MODE, 8'h01);
    enc_bytes.delete(); enc_acc = 0; enc_bits = 0; enc_grp = 0; enc_w = 9;
    put_code(8'h61); put_code(257); put_code(256); put_code(8'hfe);
    if (enc_bits > 0) emit_byte(enc_acc[7:0]);
    queue_stream();
    drain_all();

    // Random streams across settings and idling phases.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(lzwd_pkg::CFG_MAX_CODE_BITS, ph == 0 ? 8'd0 : ph == 1 ? 8'd31 :
                ph == 2 ? 8'd9 : 8'(9 + $urandom_range(7)));
      write_reg(lzwd_pkg::CFG_BLOCK_MODE, ph % 3 == 2 ? 8'h00 : 8'h01);
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 24 : 71) : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 24 : 71) : 0;
      build_stream(8 + $urandom_range(8), ph == 5 ? 3 : 255);
      queue_stream();
      // tail noise: random feeds and pops after the stream, including bad codes
      repeat (6) queue_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
      if (ph == 4) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      drain_all();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    drain_all();
    if (mismatches == 0 && expected_beats.size() == 0)
      $display("tb_lzw_compress_decoder: done, clean");
    else
      $display("tb_lzw_compress_decoder: done, errors");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/lzwd_pkg.sv
rtl/lzwd_ram.sv
rtl/lzwd_ctrl.sv
rtl/lzwd_dp.sv
rtl/lzw_compress_decoder.sv
sim/tb_lzw_compress_decoder.sv
